/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked implication checks with an asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sms_pkg.sv */
// ----------------------------------------------------------------------------
// sms_pkg
// shared types, constants and helpers of the swerve module setpoint block
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

	localparam int MAX_STEPS = 24;
	localparam int STEP_W    = 5;
	localparam int XW        = 27;
	localparam int CFG_IDX_W = 4;

	localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_X  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOUNT_Y  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 4'd3;

	// atan(2^-i) in 2^-32 turn
	localparam logic [31:0] ATAN_TURN32 [MAX_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LEV_Y,
		OP_LEV_X,
		OP_SUM,
		OP_CHECK,
		OP_ITER,
		OP_TURN,
		OP_SETP,
		OP_MAG,
		OP_RPM,
		OP_COMMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [STEP_W-1:0]   step;
	} dp_cmd_t;

	typedef struct packed {
		logic dead;
		logic out_full;
	} dp_sts_t;

	typedef struct packed {
		logic signed [15:0] mount_x;
		logic signed [15:0] mount_y;
		logic [15:0]        rpm_gain;
		logic [14:0]        deadzone;
	} cfg_t;

	// table entry rounded to 2^-frac turn
	function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i, input int frac);
		logic [32:0] t;
		logic [32:0] r;
		int          sh;
		sh = 32 - frac;
		if (int'(i) < MAX_STEPS) begin
			t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (sh - 1));
		end else begin
			t = '0;
		end
		r = t >> sh;
		return r[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		if (v > 22'sd32767) begin
			return 16'sh7fff;
		end else if (v < -22'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sms_ctrl.sv */
// ----------------------------------------------------------------------------
// sms_ctrl
// sequencer issuing the datapath operations for each command in order, holding the commit while the result is full
// ----------------------------------------------------------------------------
`default_nettype none

module sms_ctrl
	import sms_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_accept,
	input  dp_sts_t   sts,
	output dp_cmd_t   cmd,
	output logic      busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LEVY,
		S_LEVX,
		S_SUM,
		S_CHECK,
		S_DEC,
		S_ITER,
		S_TURN,
		S_SETP,
		S_MAG,
		S_RPM,
		S_FIN
	} state_t;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	state_t            state_q;
	dp_op_t            op_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			step_q  <= '0;
			busy_q  <= 1'b0;
		end else begin
			op_q <= OP_NONE;
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_LEVY;
						op_q    <= OP_LEV_Y;
						busy_q  <= 1'b1;
					end
				end
				S_LEVY: begin
					state_q <= S_LEVX;
					op_q    <= OP_LEV_X;
				end
				S_LEVX: begin
					state_q <= S_SUM;
					op_q    <= OP_SUM;
				end
				S_SUM: begin
					state_q <= S_CHECK;
					op_q    <= OP_CHECK;
				end
				S_CHECK: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (sts.dead) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_ITER;
						op_q    <= OP_ITER;
						step_q  <= '0;
					end
				end
				S_ITER: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_TURN;
						op_q    <= OP_TURN;
					end else begin
						op_q   <= OP_ITER;
						step_q <= step_q + 1'b1;
					end
				end
				S_TURN: begin
					state_q <= S_SETP;
					op_q    <= OP_SETP;
				end
				S_SETP: begin
					state_q <= S_MAG;
					op_q    <= OP_MAG;
				end
				S_MAG: begin
					state_q <= S_RPM;
					op_q    <= OP_RPM;
				end
				S_RPM: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					// result register must be free before the commit beat
					if (!sts.out_full) begin
						state_q <= S_IDLE;
						op_q    <= OP_COMMIT;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.op   = op_q;
	assign cmd.step = step_q;
	assign busy     = busy_q;

endmodule

`default_nettype wire

/* hw/rtl/sms_datapath.sv */
// ----------------------------------------------------------------------------
// sms_datapath
// lever arm, deadzone, iterative cordic, turn tracking and rpm scaling
// ----------------------------------------------------------------------------
`default_nettype none

module sms_datapath
	import sms_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cfg_t                    cfg,
	input  dp_cmd_t                 cmd,
	input  wire logic               in_accept,
	input  wire logic signed [15:0] vel_x,
	input  wire logic signed [15:0] vel_y,
	input  wire logic signed [15:0] yaw_rate,
	input  wire logic               out_stall,
	output dp_sts_t                 sts,
	output logic                    out_valid,
	output logic [15:0]             speed_rpm,
	output logic signed [31:0]      azimuth_setpoint,
	output logic                    in_deadzone
);

	localparam int ZW = ANGLE_FRAC_BITS + 2;
	localparam int DW = (ANGLE_FRAC_BITS + 18 > 33) ? ANGLE_FRAC_BITS + 18 : 33;
	localparam logic signed [ZW-1:0] ZHALF = ZW'(1) << (ANGLE_FRAC_BITS - 1);
	localparam logic signed [DW-1:0] DHALF = DW'(1) << (ANGLE_FRAC_BITS - 1);

	logic signed [15:0]   vx_q, vy_q, r_q;
	logic signed [31:0]   prod_q;
	logic signed [15:0]   mx_q, my_q;
	logic                 dead_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [DW-1:0] d_q;
	logic signed [15:0]   off_new_q;
	logic signed [31:0]   setp_q;
	logic [XW-1:0]        mag_q;
	logic [15:0]          rpm_q;
	logic signed [15:0]   off_q;
	logic signed [31:0]   last_q;
	logic                 out_valid_q;
	logic [15:0]          speed_q;
	logic signed [31:0]   az_q;
	logic                 dz_q;

	// lever terms, floor shifts
	logic signed [32:0] neg_prod;
	logic signed [21:0] sum_x, sum_y;
	// deadzone and pre-rotation
	logic [16:0]          ax, ay;
	logic signed [16:0]   mx_n, my_n;
	logic signed [XW-1:0] x0, y0;
	// cordic step
	logic signed [XW-1:0] xs, ys;
	logic [31:0]          ae;
	logic signed [ZW-1:0] at;
	// turn tracking
	logic signed [DW-1:0] z_ext, off_term, last_ext, setp_ext;
	logic signed [16:0]   off_t;
	// magnitude and rpm
	logic [XW+30:0]       prod_m;
	logic [XW+16:0]       rpm_t;

	always_comb begin
		neg_prod = -{prod_q[31], prod_q};
		sum_x    = 22'(vx_q) + 22'($signed(neg_prod[32:12]));
		sum_y    = 22'(vy_q) + 22'($signed(prod_q[31:12]));

		mx_n = -{mx_q[15], mx_q};
		my_n = -{my_q[15], my_q};
		ax   = mx_q[15] ? 17'(mx_n) : 17'(mx_q);
		ay   = my_q[15] ? 17'(my_n) : 17'(my_q);
		x0   = {{(XW-24){mx_q[15]}}, mx_q, 8'b0};
		y0   = {{(XW-24){my_q[15]}}, my_q, 8'b0};

		xs = x_q >>> cmd.step;
		ys = y_q >>> cmd.step;
		ae = atan_entry(cmd.step, ANGLE_FRAC_BITS);
		at = ae[ZW-1:0];

		z_ext    = {{(DW-ZW){z_q[ZW-1]}}, z_q};
		off_term = {{(DW-16-ANGLE_FRAC_BITS){off_q[15]}}, off_q, {ANGLE_FRAC_BITS{1'b0}}};
		last_ext = {{(DW-32){last_q[31]}}, last_q};
		setp_ext = z_ext + {{(DW-16-ANGLE_FRAC_BITS){off_new_q[15]}}, off_new_q,
			{ANGLE_FRAC_BITS{1'b0}}};

		off_t = {off_q[15], off_q};
		if (d_q > DHALF) begin
			off_t = off_t - 17'sd1;
		end else if (d_q < -DHALF) begin
			off_t = off_t + 17'sd1;
		end
		if (off_t > 17'sd32767) begin
			off_t = 17'sd32767;
		end else if (off_t < -17'sd32767) begin
			off_t = -17'sd32767;
		end

		prod_m = $unsigned(x_q) * INV_GAIN_Q31;
		rpm_t  = (XW+17)'(mag_q) * (XW+17)'(cfg.rpm_gain) + ((XW+17)'(1) << 23);
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			vx_q <= vel_x;
			vy_q <= vel_y;
			r_q  <= yaw_rate;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LEV_Y: begin
				prod_q <= r_q * cfg.mount_y;
			end
			OP_LEV_X: begin
				mx_q   <= sat16(sum_x);
				prod_q <= r_q * cfg.mount_x;
			end
			OP_SUM: begin
				my_q <= sat16(sum_y);
			end
			OP_CHECK: begin
				dead_q <= (ax <= {2'b0, cfg.deadzone}) && (ay <= {2'b0, cfg.deadzone});
				if (mx_q[15]) begin
					x_q <= -x0;
					y_q <= -y0;
					z_q <= my_q[15] ? -ZHALF : ZHALF;
				end else begin
					x_q <= x0;
					y_q <= y0;
					z_q <= '0;
				end
			end
			OP_ITER: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			OP_TURN: begin
				d_q <= z_ext + off_term - last_ext;
			end
			OP_SETP: begin
				off_new_q <= off_t[15:0];
			end
			OP_MAG: begin
				setp_q <= setp_ext[31:0];
				mag_q  <= (x_q > 0) ? prod_m[XW+30:31] : '0;
			end
			OP_RPM: begin
				rpm_q <= (|rpm_t[XW+16:40]) ? 16'hffff : rpm_t[39:24];
			end
			OP_NONE, OP_COMMIT: begin
			end
			default: begin
			end
		endcase
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_COMMIT) begin
			if (dead_q) begin
				speed_q <= '0;
				az_q    <= last_q;
				dz_q    <= 1'b1;
			end else begin
				speed_q <= rpm_q;
				az_q    <= setp_q;
				dz_q    <= 1'b0;
			end
		end
	end

	// tracking state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_COMMIT) begin
				out_valid_q <= 1'b1;
				if (!dead_q) begin
					off_q  <= off_new_q;
					last_q <= setp_q;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.dead         = dead_q;
	assign sts.out_full     = out_valid_q && out_stall;
	assign out_valid        = out_valid_q;
	assign speed_rpm        = speed_q;
	assign azimuth_setpoint = az_q;
	assign in_deadzone      = dz_q;

endmodule

`default_nettype wire

/* hw/rtl/swerve_module_setpoint.sv */
// ----------------------------------------------------------------------------
// swerve_module_setpoint
// per-module wheel speed and continuous azimuth from a chassis velocity command
// ----------------------------------------------------------------------------
// sequence: input capture, lever terms and deadzone check, then the cordic rotations,
//   turn tracking, setpoint, magnitude and rpm; a deadzone command skips to the commit
// issue: one item in flight at a time; the iterative cordic runs one rotation a cycle
//   through a single shift-add unit
// the next item is taken while a finished result still waits in the output register
// reset: arst_n clears the sequencer, result valid, turn offset and last azimuth,
//   and loads the register reset values
`default_nettype none

`include "assert_macros.svh"

module swerve_module_setpoint
	import sms_pkg::*;
#(
	parameter int CORDIC_STEPS    = 16,
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	// command channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic signed [15:0]   vel_x,
	input  wire logic signed [15:0]   vel_y,
	input  wire logic signed [15:0]   yaw_rate,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [15:0]               speed_rpm,
	output logic signed [31:0]        azimuth_setpoint,
	output logic                      in_deadzone
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    busy;
	logic    in_accept;

	// register file; the user must write it only while nothing is in flight, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mount_x  <= '0;
			cfg_q.mount_y  <= '0;
			cfg_q.rpm_gain <= 16'd16384;
			cfg_q.deadzone <= 15'd410;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MOUNT_X:  cfg_q.mount_x  <= cfg_data;
				REG_MOUNT_Y:  cfg_q.mount_y  <= cfg_data;
				REG_RPM_GAIN: cfg_q.rpm_gain <= cfg_data;
				REG_DEADZONE: cfg_q.deadzone <= cfg_data[14:0];
				default: begin
					// unmapped index, beat is dropped
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// a command beat is taken whenever the sequencer is idle
	assign in_stall  = busy;
	assign in_accept = in_valid && !in_stall;

	sms_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	sms_datapath #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.in_accept        (in_accept),
		.vel_x            (vel_x),
		.vel_y            (vel_y),
		.yaw_rate         (yaw_rate),
		.out_stall        (out_stall),
		.sts              (sts),
		.out_valid        (out_valid),
		.speed_rpm        (speed_rpm),
		.azimuth_setpoint (azimuth_setpoint),
		.in_deadzone      (in_deadzone)
	);

	// a taken command keeps the sequencer busy the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_accept, in_stall, "no busy after accept")
	// a fresh result follows the commit cycle, where the sequencer is idle
	`ASSERT_IMPL(a_commit_idle, clk, arst_n, $rose(out_valid), $past(!in_stall), "commit while busy")
	// deadzone results carry zero speed
	`ASSERT_IMPL(a_dz_speed, clk, arst_n, out_valid && in_deadzone, speed_rpm == 16'd0,
		"deadzone result with speed")

endmodule

`default_nettype wire
